FILE: design/led_key_panel_bus_master_assert.svh
// Assertion macros for the panel bus master back stage.
`ifndef LED_KEY_PANEL_BUS_MASTER_ASSERT_SVH
`define LED_KEY_PANEL_BUS_MASTER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LKP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lkp same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define LKP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkp next-cycle check failed");

`endif

FILE: design/lkp_pkg.sv
package lkp_pkg;

  localparam int DIGIT_COUNT    = 8;
  localparam int CLEAR_BYTES    = 16;
  localparam int KEY_READ_BYTES = 4;
  localparam int QUEUE_DEPTH    = 4;

  localparam int LED_RESULTS   = 2 * DIGIT_COUNT;
  localparam int INIT_RESULTS  = CLEAR_BYTES + 2;
  localparam int MAX_RESULTS   = (INIT_RESULTS > LED_RESULTS) ? INIT_RESULTS : LED_RESULTS;
  localparam int LEN_W         = $clog2(MAX_RESULTS + 1);
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] CMD_INIT       = 3'd0;
  localparam logic [2:0] CMD_CLEAR      = 3'd1;
  localparam logic [2:0] CMD_SET_SEG    = 3'd2;
  localparam logic [2:0] CMD_SET_LEDS   = 3'd3;
  localparam logic [2:0] CMD_BRIGHTNESS = 3'd4;
  localparam logic [2:0] CMD_READ_KEYS  = 3'd5;
  localparam logic [2:0] CMD_KEY_BYTE   = 3'd6;

  localparam logic [7:0] BYTE_DISPLAY_ON = 8'h8f;
  localparam logic [7:0] BYTE_READ_KEYS  = 8'h42;
  localparam logic [7:0] BYTE_ADDR_BASE  = 8'hc0;
  localparam logic [7:0] BYTE_BRIGHT     = 8'h80;
  localparam logic [7:0] BYTE_ONE        = 8'h01;
  localparam logic [7:0] BYTE_ZERO       = 8'h00;

  typedef enum logic [2:0] {
    JOB_INIT,
    JOB_CLEAR,
    JOB_SEG,
    JOB_LEDS,
    JOB_BRIGHT,
    JOB_READ,
    JOB_KEYS
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [2:0] position;
    logic [7:0] value;
  } job_t;

  function automatic logic [LEN_W-1:0] job_length(job_kind_t kind);
    logic [LEN_W-1:0] len;
    case (kind)
      JOB_INIT:  len = LEN_W'(INIT_RESULTS);
      JOB_CLEAR: len = LEN_W'(CLEAR_BYTES + 1);
      JOB_SEG:   len = LEN_W'(3);
      JOB_LEDS:  len = LEN_W'(LED_RESULTS);
      default:   len = LEN_W'(1);
    endcase
    return len;
  endfunction

endpackage

FILE: design/lkp_cmd_if.sv
interface lkp_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [2:0] position;
  logic [7:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink (input valid, command, position, value, output ready);
endinterface

FILE: design/lkp_res_if.sv
interface lkp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] bus_byte;
  logic       frame_end;
  logic       keys_valid;
  logic [7:0] key_state;
  logic       expect_reads;
  logic       last;

  modport source (output valid, bus_byte, frame_end, keys_valid, key_state,
                  expect_reads, last, input ready);
  modport sink (input valid, bus_byte, frame_end, keys_valid, key_state,
                expect_reads, last, output ready);
endinterface

FILE: design/lkp_front.sv
module lkp_front (
  input  logic          clk,
  input  logic          rst,
  lkp_cmd_if.sink       cmd,
  input  logic          queue_full,
  output logic          push,
  output lkp_pkg::job_t push_job
);

  logic       reading;
  logic [2:0] reads_taken;
  logic [7:0] key_accumulator;
  logic       reading_next;
  logic [2:0] reads_taken_next;
  logic [7:0] key_accumulator_next;
  logic       accept;

  assign cmd.ready = !queue_full;
  assign accept    = cmd.valid && cmd.ready;

  always_comb begin
    push                 = 1'b0;
    push_job.kind        = lkp_pkg::JOB_INIT;
    push_job.position    = cmd.position;
    push_job.value       = cmd.value;
    reading_next         = reading;
    reads_taken_next     = reads_taken;
    key_accumulator_next = key_accumulator;
    if (accept) begin
      if (reading) begin
        if (cmd.command == lkp_pkg::CMD_KEY_BYTE) begin
          key_accumulator_next = key_accumulator | (cmd.value << reads_taken);
          reads_taken_next     = reads_taken + 3'd1;
          if (reads_taken_next >= 3'(lkp_pkg::KEY_READ_BYTES)) begin
            push             = 1'b1;
            push_job.kind    = lkp_pkg::JOB_KEYS;
            push_job.value   = key_accumulator_next;
            reading_next     = 1'b0;
            reads_taken_next = 3'd0;
          end
        end
      end else begin
        case (cmd.command)
          lkp_pkg::CMD_INIT: begin
            push          = 1'b1;
            push_job.kind = lkp_pkg::JOB_INIT;
          end
          lkp_pkg::CMD_CLEAR: begin
            push          = 1'b1;
            push_job.kind = lkp_pkg::JOB_CLEAR;
          end
          lkp_pkg::CMD_SET_SEG: begin
            push          = {1'b0, cmd.position} < 4'(lkp_pkg::DIGIT_COUNT);
            push_job.kind = lkp_pkg::JOB_SEG;
          end
          lkp_pkg::CMD_SET_LEDS: begin
            push          = 1'b1;
            push_job.kind = lkp_pkg::JOB_LEDS;
          end
          lkp_pkg::CMD_BRIGHTNESS: begin
            push          = 1'b1;
            push_job.kind = lkp_pkg::JOB_BRIGHT;
          end
          lkp_pkg::CMD_READ_KEYS: begin
            push                 = 1'b1;
            push_job.kind        = lkp_pkg::JOB_READ;
            reading_next         = 1'b1;
            reads_taken_next     = 3'd0;
            key_accumulator_next = 8'd0;
          end
          default: begin
            push = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reading         <= 1'b0;
      reads_taken     <= 3'd0;
      key_accumulator <= 8'd0;
    end else begin
      reading         <= reading_next;
      reads_taken     <= reads_taken_next;
      key_accumulator <= key_accumulator_next;
    end
  end

endmodule

FILE: design/lkp_job_queue.sv
module lkp_job_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lkp_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output lkp_pkg::job_t pop_job,
  output logic          empty
);

  lkp_pkg::job_t                 entries [lkp_pkg::QUEUE_DEPTH];
  logic [lkp_pkg::QPTR_W-1:0]    wr_ptr;
  logic [lkp_pkg::QPTR_W-1:0]    rd_ptr;
  logic [lkp_pkg::QPTR_W:0]      count;
  logic                          do_push;
  logic                          do_pop;

  assign full    = count == (lkp_pkg::QPTR_W + 1)'(lkp_pkg::QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/lkp_back.sv
`include "led_key_panel_bus_master_assert.svh"

module lkp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          queue_empty,
  input  lkp_pkg::job_t pop_job,
  output logic          pop,
  lkp_res_if.source     res
);

  logic                      busy;
  lkp_pkg::job_t             job;
  logic [lkp_pkg::LEN_W-1:0] cnt;
  logic                      out_free;
  logic                      is_last;
  logic [2:0]                led_idx;
  logic [7:0]                byte_now;
  logic                      fend_now;
  logic                      keys_now;
  logic                      expect_now;

  assign out_free = !res.valid || res.ready;
  assign pop      = !busy && !queue_empty;
  assign is_last  = cnt == (lkp_pkg::job_length(job.kind) - 1'b1);
  assign led_idx  = 3'(cnt >> 1);

  always_comb begin
    byte_now   = lkp_pkg::BYTE_ZERO;
    fend_now   = 1'b0;
    keys_now   = 1'b0;
    expect_now = 1'b0;
    case (job.kind)
      lkp_pkg::JOB_INIT: begin
        if (cnt == '0) begin
          byte_now = lkp_pkg::BYTE_DISPLAY_ON;
          fend_now = 1'b1;
        end else if (cnt == lkp_pkg::LEN_W'(1)) begin
          byte_now = lkp_pkg::BYTE_ADDR_BASE;
        end else begin
          fend_now = is_last;
        end
      end
      lkp_pkg::JOB_CLEAR: begin
        if (cnt == '0) begin
          byte_now = lkp_pkg::BYTE_ADDR_BASE;
        end else begin
          fend_now = is_last;
        end
      end
      lkp_pkg::JOB_SEG: begin
        if (cnt == '0) begin
          byte_now = lkp_pkg::BYTE_ADDR_BASE;
          fend_now = 1'b1;
        end else if (cnt == lkp_pkg::LEN_W'(1)) begin
          byte_now = lkp_pkg::BYTE_ADDR_BASE | {4'd0, job.position, 1'b0};
        end else begin
          byte_now = job.value;
          fend_now = 1'b1;
        end
      end
      lkp_pkg::JOB_LEDS: begin
        if (!cnt[0]) begin
          byte_now = lkp_pkg::BYTE_ADDR_BASE | {4'd0, led_idx, 1'b1};
        end else begin
          byte_now = job.value[led_idx] ? lkp_pkg::BYTE_ONE : lkp_pkg::BYTE_ZERO;
          fend_now = 1'b1;
        end
      end
      lkp_pkg::JOB_BRIGHT: begin
        byte_now = lkp_pkg::BYTE_BRIGHT | {4'd0, job.value[3:0]};
        fend_now = 1'b1;
      end
      lkp_pkg::JOB_READ: begin
        byte_now   = lkp_pkg::BYTE_READ_KEYS;
        expect_now = 1'b1;
      end
      lkp_pkg::JOB_KEYS: begin
        fend_now = 1'b1;
        keys_now = 1'b1;
      end
      default: begin
        byte_now = lkp_pkg::BYTE_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      res.valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        job  <= pop_job;
        cnt  <= '0;
      end
      if (busy && out_free) begin
        res.valid        <= 1'b1;
        res.bus_byte     <= byte_now;
        res.frame_end    <= fend_now;
        res.keys_valid   <= keys_now;
        res.key_state    <= keys_now ? job.value : 8'd0;
        res.expect_reads <= expect_now;
        res.last         <= is_last;
        cnt              <= cnt + 1'b1;
        if (is_last) begin
          busy <= 1'b0;
        end
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  `LKP_ASSERT_IMP(a_keys_close, res.valid && res.keys_valid, res.frame_end && res.last)
  `LKP_ASSERT_IMP(a_keys_byte, res.valid && res.keys_valid, res.bus_byte == lkp_pkg::BYTE_ZERO)
  `LKP_ASSERT_IMP(a_last_frames, res.valid && res.last, res.frame_end || res.expect_reads)
  `LKP_ASSERT_NEXT(a_pop_loads, pop, busy && cnt == '0)
  `LKP_ASSERT_IMP(a_cnt_range, busy, cnt < lkp_pkg::job_length(job.kind))

endmodule

FILE: design/led_key_panel_bus_master.sv
// Channel  Direction  Fields
// cmd      in         command[2:0], position[2:0], value[7:0]
// res      out        bus_byte[7:0], frame_end, keys_valid, key_state[7:0],
//                     expect_reads, last
//
// The front stage takes one command per cycle while the four-entry job queue has room.
// The back stage loads a job, then registers its results one at a time, holding while the output stalls:
// 18 results for init, 17 for clear, 16 for set leds, 3 for set segment, 1 otherwise.
// Its result counter sets the sustained rate; commands without results only occupy the front stage.
// A stalled result holds in the output register while the front keeps filling the queue.
// Synchronous reset clears the read state, the queue and the output valid.
module led_key_panel_bus_master (
  input  logic      clk,
  input  logic      rst,
  lkp_cmd_if.sink   cmd,
  lkp_res_if.source res
);

  logic          push;
  lkp_pkg::job_t push_job;
  logic          queue_full;
  logic          pop;
  lkp_pkg::job_t pop_job;
  logic          queue_empty;

  lkp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  lkp_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (queue_empty)
  );

  lkp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .pop_job     (pop_job),
    .pop         (pop),
    .res         (res)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 340;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_GAP      = 20;
  localparam int MAX_REPORTS  = 50;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       frame_end;
    logic       keys_valid;
    logic [7:0] key_state;
    logic       expect_reads;
    logic       last;
  } panel_result_t;

  logic clk;
  logic rst;

  lkp_cmd_if cmd_bus ();
  lkp_res_if res_bus ();

  led_key_panel_bus_master dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus)
  );

  panel_result_t pending_results[$];
  logic          in_read;
  logic [2:0]    reads_done;
  logic [7:0]    key_acc;

  int error_count;
  int effective_items;
  int stall_pct;
  int hold_req;
  bit gaps_enabled;
  int burst_left;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic void push_result(input logic [7:0] bus_byte, input logic frame_end,
                                      input logic keys_valid, input logic [7:0] key_state,
                                      input logic expect_reads);
    panel_result_t r;
    r.bus_byte     = bus_byte;
    r.frame_end    = frame_end;
    r.keys_valid   = keys_valid;
    r.key_state    = key_state;
    r.expect_reads = expect_reads;
    r.last         = 1'b0;
    pending_results.push_back(r);
  endfunction

  function automatic void push_clear_frame();
    push_result(lkp_pkg::BYTE_ADDR_BASE, 1'b0, 1'b0, 8'h00, 1'b0);
    for (int i = 0; i < lkp_pkg::CLEAR_BYTES; i++) begin
      push_result(lkp_pkg::BYTE_ZERO, i == lkp_pkg::CLEAR_BYTES - 1, 1'b0, 8'h00, 1'b0);
    end
  endfunction

  function automatic bit predict_panel_bytes(input logic [2:0] command,
                                             input logic [2:0] position,
                                             input logic [7:0] value);
    int  start;
    bit  effective;
    start     = pending_results.size();
    effective = 1'b0;
    if (in_read) begin
      if (command == lkp_pkg::CMD_KEY_BYTE) begin
        effective  = 1'b1;
        key_acc    = key_acc | (value << reads_done);
        reads_done = reads_done + 3'd1;
        if (reads_done >= lkp_pkg::KEY_READ_BYTES) begin
          push_result(lkp_pkg::BYTE_ZERO, 1'b1, 1'b1, key_acc, 1'b0);
          in_read    = 1'b0;
          reads_done = 3'd0;
        end
      end
    end else begin
      case (command)
        lkp_pkg::CMD_INIT: begin
          push_result(lkp_pkg::BYTE_DISPLAY_ON, 1'b1, 1'b0, 8'h00, 1'b0);
          push_clear_frame();
        end
        lkp_pkg::CMD_CLEAR: begin
          push_clear_frame();
        end
        lkp_pkg::CMD_SET_SEG: begin
          if (position < lkp_pkg::DIGIT_COUNT) begin
            push_result(lkp_pkg::BYTE_ADDR_BASE, 1'b1, 1'b0, 8'h00, 1'b0);
            push_result(lkp_pkg::BYTE_ADDR_BASE | {4'h0, position, 1'b0},
                        1'b0, 1'b0, 8'h00, 1'b0);
            push_result(value, 1'b1, 1'b0, 8'h00, 1'b0);
          end
        end
        lkp_pkg::CMD_SET_LEDS: begin
          for (int i = 0; i < lkp_pkg::DIGIT_COUNT; i++) begin
            push_result(lkp_pkg::BYTE_ADDR_BASE | 8'(i * 2 + 1), 1'b0, 1'b0, 8'h00, 1'b0);
            push_result(value[i] ? lkp_pkg::BYTE_ONE : lkp_pkg::BYTE_ZERO,
                        1'b1, 1'b0, 8'h00, 1'b0);
          end
        end
        lkp_pkg::CMD_BRIGHTNESS: begin
          push_result(lkp_pkg::BYTE_BRIGHT | {4'h0, value[3:0]}, 1'b1, 1'b0, 8'h00, 1'b0);
        end
        lkp_pkg::CMD_READ_KEYS: begin
          push_result(lkp_pkg::BYTE_READ_KEYS, 1'b0, 1'b0, 8'h00, 1'b1);
          in_read    = 1'b1;
          reads_done = 3'd0;
          key_acc    = 8'h00;
        end
        default: begin
        end
      endcase
    end
    if (pending_results.size() > start) begin
      pending_results[pending_results.size() - 1].last = 1'b1;
      effective = 1'b1;
    end
    return effective;
  endfunction

  task automatic send_command(input logic [2:0] command, input logic [2:0] position,
                              input logic [7:0] value);
    int gap;
    cmd_bus.valid    <= 1'b1;
    cmd_bus.command  <= command;
    cmd_bus.position <= position;
    cmd_bus.value    <= value;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    if (predict_panel_bytes(command, position, value)) effective_items++;
    if (gaps_enabled) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 8);
        gap = $urandom_range(1, MAX_GAP);
        cmd_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    cmd_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_value();
    logic [7:0] v;
    case ($urandom_range(0, 7))
      0: v = 8'h00;
      1: v = 8'hff;
      default: v = 8'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_noise_in_read();
    logic [2:0] c;
    c = 3'($urandom_range(0, 6));
    if (c == lkp_pkg::CMD_KEY_BYTE) c = CMD_UNUSED;
    send_command(c, 3'($urandom), random_value());
  endtask

  task automatic send_key_read();
    send_command(lkp_pkg::CMD_READ_KEYS, 3'($urandom), random_value());
    for (int k = 0; k < lkp_pkg::KEY_READ_BYTES; k++) begin
      if ($urandom_range(0, 4) == 0) send_noise_in_read();
      send_command(lkp_pkg::CMD_KEY_BYTE, 3'($urandom), random_value());
    end
  endtask

  task automatic test_display_commands();
    send_command(lkp_pkg::CMD_INIT, 3'd0, 8'h00);
    send_command(lkp_pkg::CMD_CLEAR, 3'd7, 8'hff);
    send_command(lkp_pkg::CMD_SET_SEG, 3'd0, 8'h00);
    send_command(lkp_pkg::CMD_SET_SEG, 3'd7, 8'hff);
    send_command(lkp_pkg::CMD_SET_LEDS, 3'd0, 8'h00);
    send_command(lkp_pkg::CMD_SET_LEDS, 3'd7, 8'hff);
    send_command(lkp_pkg::CMD_SET_LEDS, 3'd2, 8'ha5);
    send_command(lkp_pkg::CMD_BRIGHTNESS, 3'd0, 8'h00);
    send_command(lkp_pkg::CMD_BRIGHTNESS, 3'd5, 8'hff);
  endtask

  task automatic test_key_reads();
    send_command(lkp_pkg::CMD_READ_KEYS, 3'd0, 8'h00);
    repeat (lkp_pkg::KEY_READ_BYTES) send_command(lkp_pkg::CMD_KEY_BYTE, 3'd0, 8'hff);
    // Commands other than a key byte are dropped while the read frame is open.
    send_command(lkp_pkg::CMD_READ_KEYS, 3'd7, 8'hff);
    send_command(lkp_pkg::CMD_INIT, 3'd0, 8'h00);
    send_command(lkp_pkg::CMD_KEY_BYTE, 3'd0, 8'h01);
    send_command(lkp_pkg::CMD_READ_KEYS, 3'd1, 8'h55);
    send_command(CMD_UNUSED, 3'd7, 8'hff);
    send_command(lkp_pkg::CMD_KEY_BYTE, 3'd7, 8'h80);
    send_command(lkp_pkg::CMD_BRIGHTNESS, 3'd3, 8'h0f);
    send_command(lkp_pkg::CMD_KEY_BYTE, 3'd3, 8'h40);
    send_command(lkp_pkg::CMD_KEY_BYTE, 3'd5, 8'h10);
  endtask

  task automatic test_ignored_items();
    send_command(lkp_pkg::CMD_KEY_BYTE, 3'd7, 8'hff);
    send_command(CMD_UNUSED, 3'd0, 8'h00);
  endtask

  task automatic test_output_stall();
    gaps_enabled = 1'b0;
    hold_req++;
    repeat (16) send_command(3'($urandom_range(0, 4)), 3'($urandom), random_value());
    gaps_enabled = 1'b1;
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    start = effective_items;
    while (effective_items - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 39) == 0) begin
        stall_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
        gaps_enabled = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_key_read();
      end else if (pick < 22) begin
        send_command(($urandom_range(0, 1) == 0) ? lkp_pkg::CMD_KEY_BYTE : CMD_UNUSED,
                     3'($urandom), random_value());
      end else begin
        send_command(3'($urandom_range(0, 4)), 3'($urandom), random_value());
      end
    end
  endtask

  initial begin
    int hold_seen;
    int hold_left;
    int stall_left;
    hold_seen  = 0;
    hold_left  = 0;
    stall_left = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 15);
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    panel_result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer, bus_byte %0h", res_bus.bus_byte));
      end else begin
        want = pending_results.pop_front();
        check_field("bus_byte", res_bus.bus_byte, want.bus_byte);
        check_field("frame_end", res_bus.frame_end, want.frame_end);
        check_field("keys_valid", res_bus.keys_valid, want.keys_valid);
        check_field("key_state", res_bus.key_state, want.key_state);
        check_field("expect_reads", res_bus.expect_reads, want.expect_reads);
        check_field("last", res_bus.last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_read         = 1'b0;
    reads_done      = 3'd0;
    key_acc         = 8'h00;
    error_count     = 0;
    effective_items = 0;
    stall_pct       = 20;
    hold_req        = 0;
    gaps_enabled    = 1'b1;
    burst_left      = 0;
    idle_cycles     = 0;
    rst              <= 1'b1;
    cmd_bus.valid    <= 1'b0;
    cmd_bus.command  <= lkp_pkg::CMD_INIT;
    cmd_bus.position <= 3'd0;
    cmd_bus.value    <= 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_display_commands();
    wait_drained();
    test_key_reads();
    test_ignored_items();
    wait_drained();
    test_output_stall();
    wait_drained();
    test_random_traffic();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/lkp_pkg.sv
design/lkp_cmd_if.sv
design/lkp_res_if.sv
design/lkp_front.sv
design/lkp_job_queue.sv
design/lkp_back.sv
design/led_key_panel_bus_master.sv
test/tb_top.sv
